>>> rtl/core/bffa_pkg.sv
package bffa_pkg;

    // fixed field widths
    localparam int CNT_W    = 11;
    localparam int FIRST_W  = 10;
    localparam int ALIGN_W  = 11;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;

    localparam logic [CFG_W-1:0] PAGES_RESET = 11'd1024;

    // request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NO_MEM = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_START,
        OP_SEXAM,
        OP_STEP,
        OP_MWRITE,
        OP_EMIT
    } dp_op_t;

    // controller states
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_START = 9'b000000100,
        S_SREAD = 9'b000001000,
        S_SEXAM = 9'b000010000,
        S_STEP  = 9'b000100000,
        S_MREAD = 9'b001000000,
        S_MWRT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        dp_op_t  op;
        logic    set_res;
        status_t res_code;
        logic    take_start;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic free_op;
        logic range_bad;
        logic count_zero;
        logic no_fit;
        logic hit;
        logic align_pow2;
        logic run_done;
        logic step_done;
        logic mark_last;
        logic out_busy;
    } dp_sts_t;

endpackage

>>> rtl/core/bffa_ctrl.sv
module bffa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bffa_pkg::dp_sts_t sts,
    output bffa_pkg::dp_cmd_t cmd
);
    import bffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        cmd.set_res    = 1'b0;
        cmd.res_code   = ST_OK;
        cmd.take_start = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.op = OP_START;
                if (sts.free_op)
                begin
                    cmd.set_res = 1'b1;
                    if (sts.range_bad)
                    begin
                        cmd.res_code = ST_RANGE;
                        state_next   = S_DONE;
                    end
                    else if (sts.count_zero)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MREAD;
                    end
                end
                else
                begin
                    state_next = S_SREAD;
                end
            end
            S_SREAD:
            begin
                if (sts.no_fit)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NO_MEM;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_SEXAM;
                end
            end
            S_SEXAM:
            begin
                cmd.op = OP_SEXAM;
                if (sts.hit)
                begin
                    state_next = sts.align_pow2 ? S_SREAD : S_STEP;
                end
                else if (sts.run_done)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.take_start = 1'b1;
                    state_next     = sts.count_zero ? S_DONE : S_MREAD;
                end
                else
                begin
                    state_next = S_SREAD;
                end
            end
            S_STEP:
            begin
                cmd.op = OP_STEP;
                if (sts.step_done)
                begin
                    state_next = S_SREAD;
                end
            end
            S_MREAD:
            begin
                state_next = S_MWRT;
            end
            S_MWRT:
            begin
                cmd.op     = OP_MWRITE;
                state_next = sts.mark_last ? S_DONE : S_MREAD;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/bffa_dpath.sv
module bffa_dpath
#(
    parameter int MAX_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bffa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           mode,
    input  logic [bffa_pkg::CNT_W-1:0]     page_count,
    input  logic [bffa_pkg::FIRST_W-1:0]   first_page,
    input  logic [bffa_pkg::ALIGN_W-1:0]   alignment,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bffa_pkg::STATUS_W-1:0]  status,
    output logic [bffa_pkg::START_W-1:0]   start_page,
    input  bffa_pkg::dp_cmd_t              cmd,
    output bffa_pkg::dp_sts_t              sts
);
    import bffa_pkg::*;

    // storage words are the largest power of two not above MAP_WORD_BITS
    localparam int WB         = $clog2(MAP_WORD_BITS + 1) - 1;
    localparam int STORE_BITS = 1 << WB;
    localparam int WORDS      = (MAX_PAGES + STORE_BITS - 1) / STORE_BITS;
    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW         = $clog2(MAX_PAGES);
    localparam int POS_W      = ((PW > CNT_W) ? PW : CNT_W) + 2;

    // bitmap memory
    logic [STORE_BITS-1:0] mem [WORDS];
    logic [STORE_BITS-1:0] rdata_reg;

    // configuration and request registers
    logic [CFG_W-1:0]    pages_reg;
    logic                mode_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [FIRST_W-1:0]  first_reg;
    logic [ALIGN_W-1:0]  align_reg;

    // scan and mark pointers
    logic [POS_W-1:0]    cand_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    mend_reg;
    logic [POS_W-1:0]    hit_reg;
    logic                mark_set_reg;
    logic [AW-1:0]       clr_reg;

    // result and output registers
    status_t             res_status_reg;
    logic [START_W-1:0]  res_start_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [START_W-1:0]  out_start_reg;

    logic [POS_W-1:0]      limit;
    logic [ALIGN_W-1:0]    align_eff;
    logic [CNT_W-1:0]      run_len;
    logic [POS_W-1:0]      scan_end;
    logic [POS_W-1:0]      pos_word;
    logic [AW-1:0]         addr;
    logic [WB-1:0]         lo_off;
    logic [POS_W-1:0]      wbase;
    logic [POS_W-1:0]      wnext;
    logic [POS_W-1:0]      span;
    logic [POS_W-1:0]      mark_span;
    logic [STORE_BITS-1:0] win_mask;
    logic [STORE_BITS-1:0] mark_mask;
    logic [STORE_BITS-1:0] taken;
    logic [WB-1:0]         first_idx;
    logic                  hit;
    logic                  win_fits;
    logic                  mark_fits;
    logic [POS_W-1:0]      hit_pos;
    logic [POS_W-1:0]      pow2_next;
    logic [POS_W-1:0]      step_next;
    logic                  mem_we;
    logic [AW-1:0]         waddr;
    logic [STORE_BITS-1:0] mem_wdata;

    // effective limits and run length
    always_comb
    begin
        if (POS_W'(pages_reg) > POS_W'(MAX_PAGES))
        begin
            limit = POS_W'(MAX_PAGES);
        end
        else
        begin
            limit = POS_W'(pages_reg);
        end
        align_eff = (align_reg == '0) ? ALIGN_W'(1) : align_reg;
        run_len   = (count_reg == '0) ? CNT_W'(1) : count_reg;
        scan_end  = cand_reg + POS_W'(run_len);
    end

    // current word, scan window and mark window
    assign pos_word  = pos_reg >> WB;
    assign addr      = pos_word[AW-1:0];
    assign lo_off    = pos_reg[WB-1:0];
    assign wbase     = pos_reg & ~POS_W'(STORE_BITS - 1);
    assign wnext     = wbase + POS_W'(STORE_BITS);
    assign span      = scan_end - wbase;
    assign mark_span = mend_reg - wbase;
    assign win_fits  = (scan_end <= wnext);
    assign mark_fits = (mend_reg <= wnext);

    // window masks over the word and lowest taken page in the scan window
    always_comb
    begin
        for (int b = 0; b < STORE_BITS; b++)
        begin
            win_mask[b]  = (WB'(b) >= lo_off) && (POS_W'(b) < span);
            mark_mask[b] = (WB'(b) >= lo_off) && (POS_W'(b) < mark_span);
        end
        taken     = rdata_reg & win_mask;
        hit       = |taken;
        first_idx = '0;
        for (int b = STORE_BITS - 1; b >= 0; b--)
        begin
            if (taken[b])
            begin
                first_idx = WB'(b);
            end
        end
    end

    // candidate advance past a taken page
    assign hit_pos   = wbase | POS_W'(first_idx);
    assign pow2_next = (hit_pos | (POS_W'(align_eff) - POS_W'(1))) + POS_W'(1);
    assign step_next = cand_reg + POS_W'(align_eff);

    // status towards the controller
    always_comb
    begin
        sts.clr_last   = (clr_reg == AW'(WORDS - 1));
        sts.free_op    = (mode_reg == MODE_FREE);
        sts.range_bad  = (POS_W'(first_reg) + POS_W'(count_reg)) > limit;
        sts.count_zero = (count_reg == '0);
        sts.no_fit     = (scan_end > limit);
        sts.hit        = hit;
        sts.align_pow2 = ((align_eff & (align_eff - ALIGN_W'(1))) == '0);
        sts.run_done   = !hit && win_fits;
        sts.step_done  = (step_next > hit_reg);
        sts.mark_last  = mark_fits;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    // memory write port: clearing pass or read-modify-write of a mark
    always_comb
    begin
        mem_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_MWRITE);
        waddr     = (cmd.op == OP_CLEAR) ? clr_reg : addr;
        mem_wdata = '0;
        if (cmd.op == OP_MWRITE)
        begin
            mem_wdata = mark_set_reg ? (rdata_reg | mark_mask) : (rdata_reg & ~mark_mask);
        end
    end

    // bitmap storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg     <= PAGES_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pages_reg <= cfg_wdata;
            end
            if (cmd.op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg  <= mode;
                count_reg <= page_count;
                first_reg <= first_page;
                align_reg <= alignment;
            end
            OP_START:
            begin
                cand_reg     <= '0;
                pos_reg      <= (mode_reg == MODE_FREE) ? POS_W'(first_reg) : '0;
                mend_reg     <= POS_W'(first_reg) + POS_W'(count_reg);
                mark_set_reg <= (mode_reg == MODE_ALLOC);
            end
            OP_SEXAM:
            begin
                if (hit)
                begin
                    hit_reg <= hit_pos;
                    if (sts.align_pow2)
                    begin
                        cand_reg <= pow2_next;
                        pos_reg  <= pow2_next;
                    end
                end
                else if (win_fits)
                begin
                    pos_reg  <= cand_reg;
                    mend_reg <= cand_reg + POS_W'(count_reg);
                end
                else
                begin
                    pos_reg <= wnext;
                end
            end
            OP_STEP:
            begin
                cand_reg <= step_next;
                pos_reg  <= step_next;
            end
            OP_MWRITE:
            begin
                pos_reg <= wnext;
            end
            OP_EMIT:
            begin
                out_status_reg <= res_status_reg;
                out_start_reg  <= res_start_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_code;
            res_start_reg  <= cmd.take_start ? cand_reg[START_W-1:0] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign start_page = out_start_reg;

endmodule

>>> rtl/core/bitmap_first_fit_allocator_unit.sv
// Bitmap first-fit page allocator.
// Input channel (in_valid/in_ready) carries one request: mode 0 allocates
// page_count pages at the first start that is a multiple of alignment,
// mode 1 frees page_count pages from first_page. Output channel
// (out_valid/out_ready) returns status and start_page, one per request.
// cfg_we/cfg_wdata set pages_in_use; write it only while idle.
// A free checks the range, then reads and writes back each bitmap word
// it clears; out of range or with a zero count it touches no word.
// An allocate reads the bitmap word by word from the candidate start,
// steps the candidate through the alignment after a taken page when the
// alignment is not a power of two (else jumps past it), then reads and
// writes back each word it marks. Each taken page met restarts the scan
// at the next candidate. One request is in flight at a time; the next
// transfer can be taken in the cycle after the result is loaded,
// even while that result still waits in the output register.
// Reset: a clearing pass writes every bitmap word to free, one word per
// cycle, with in_ready low. A stalled receiver holds the result; the
// block then finishes the next request and waits until the output
// register is free.
module bitmap_first_fit_allocator_unit
#(
    parameter int MAX_PAGES     = 1024,
    parameter int MAP_WORD_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bffa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [bffa_pkg::CNT_W-1:0]     page_count,
    input  logic [bffa_pkg::FIRST_W-1:0]   first_page,
    input  logic [bffa_pkg::ALIGN_W-1:0]   alignment,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bffa_pkg::STATUS_W-1:0]  status,
    output logic [bffa_pkg::START_W-1:0]   start_page
);
    import bffa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer
    bffa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // bitmap, pointers and result registers
    bffa_dpath
    #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mode       (mode),
        .page_count (page_count),
        .first_page (first_page),
        .alignment  (alignment),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .start_page (start_page),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

>>> rtl/core/bffa_checker.sv
module bffa_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_we,
    input logic [bffa_pkg::CFG_W-1:0]     cfg_wdata,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           mode,
    input logic [bffa_pkg::CNT_W-1:0]     page_count,
    input logic [bffa_pkg::FIRST_W-1:0]   first_page,
    input logic [bffa_pkg::ALIGN_W-1:0]   alignment,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bffa_pkg::STATUS_W-1:0]  status,
    input logic [bffa_pkg::START_W-1:0]   start_page
);
    import bffa_pkg::*;

    // a held result stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(start_page))
        else $error("result changed while stalled");

    // only defined result codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NO_MEM || status == ST_RANGE))
        else $error("undefined status code");

    // failures carry no start page
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> start_page == '0)
        else $error("start page set on failure");

    // one request in flight: no transfer in the cycle after one
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind bitmap_first_fit_allocator_unit bffa_checker u_bffa_checker (.*);
